@@ rtl/core/ptsb_pkg.sv @@
package ptsb_pkg;

    localparam logic [1:0] KIND_ADD_OK   = 2'd0;
    localparam logic [1:0] KIND_ADD_REJ  = 2'd1;
    localparam logic [1:0] KIND_EXPIRY   = 2'd2;
    localparam logic [1:0] KIND_NO_EXP   = 2'd3;

    localparam logic [3:0] MAX_RESULTS   = 4'd8;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef struct packed {
        logic capture;
        logic add_take;
        logic add_reject;
        logic idx_inc;
        logic tick_rd;
        logic tick_upd;
        logic tick_fin;
    } ptsb_ctl_t;

    typedef struct packed {
        logic cmd_tick;
        logic add_bad;
        logic cur_active;
        logic idx_last;
        logic out_free;
        logic upd_needs_out;
    } ptsb_sts_t;

endpackage

@@ rtl/core/periodic_timer_slot_bank_core.sv @@
// Add: the transfer is captured and dispatched, then the slots are scanned one per cycle from slot 0
// to the first free one; a full bank, a bad period or a missing handler gives a rejection.
// Tick: each slot takes a memory read and an update, then a final result; output stalls hold it.
// One item in flight at a time; a new transfer is taken only once the last result is registered.
// Reset (aresetn, synchronous, active low) frees every slot and clears control state;
// the slot memories are not cleared.
module periodic_timer_slot_bank_core
    import ptsb_pkg::*;
#(
    parameter int SLOTS = 8
)
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_command,
    input  logic [31:0] s_period,
    input  logic        s_handler_present,
    input  logic [7:0]  s_handler_id,
    input  logic [15:0] s_argument_tag,
    input  logic [7:0]  s_disable_mask,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [2:0]  m_slot,
    output logic [7:0]  m_expired_handler,
    output logic [15:0] m_expired_tag,
    output logic        m_last
);

    ptsb_ctl_t ctl;
    ptsb_sts_t sts;

    ptsb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .ctl     (ctl)
    );

    ptsb_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .ctl               (ctl),
        .sts               (sts),
        .s_command         (s_command),
        .s_period          (s_period),
        .s_handler_present (s_handler_present),
        .s_handler_id      (s_handler_id),
        .s_argument_tag    (s_argument_tag),
        .s_disable_mask    (s_disable_mask),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_kind            (m_kind),
        .m_slot            (m_slot),
        .m_expired_handler (m_expired_handler),
        .m_expired_tag     (m_expired_tag),
        .m_last            (m_last)
    );

endmodule

@@ rtl/core/ptsb_ctrl.sv @@
module ptsb_ctrl
    import ptsb_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  ptsb_sts_t sts,
    output ptsb_ctl_t ctl
);

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_DISPATCH = 7'b0000010,
        ST_ADD_SCAN = 7'b0000100,
        ST_REJECT   = 7'b0001000,
        ST_TICK_RD  = 7'b0010000,
        ST_TICK_EX  = 7'b0100000,
        ST_TICK_FIN = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ctl        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ctl.capture = 1'b1;
                    state_next  = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (sts.cmd_tick) begin
                    state_next = ST_TICK_RD;
                end else if (sts.add_bad) begin
                    state_next = ST_REJECT;
                end else begin
                    state_next = ST_ADD_SCAN;
                end
            end
            ST_ADD_SCAN: begin
                if (!sts.cur_active) begin
                    if (sts.out_free) begin
                        ctl.add_take = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end else if (sts.idx_last) begin
                    state_next = ST_REJECT;
                end else begin
                    ctl.idx_inc = 1'b1;
                end
            end
            ST_REJECT: begin
                if (sts.out_free) begin
                    ctl.add_reject = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_TICK_RD: begin
                ctl.tick_rd = 1'b1;
                state_next  = ST_TICK_EX;
            end
            ST_TICK_EX: begin
                if (!sts.upd_needs_out || sts.out_free) begin
                    ctl.tick_upd = 1'b1;
                    if (sts.idx_last) begin
                        state_next = ST_TICK_FIN;
                    end else begin
                        ctl.idx_inc = 1'b1;
                        state_next  = ST_TICK_RD;
                    end
                end
            end
            ST_TICK_FIN: begin
                if (sts.out_free) begin
                    ctl.tick_fin = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/ptsb_dp.sv @@
module ptsb_dp
    import ptsb_pkg::*;
#(
    parameter int SLOTS = 8
)
(
    input  logic        aclk,
    input  logic        aresetn,
    input  ptsb_ctl_t   ctl,
    output ptsb_sts_t   sts,
    input  logic        s_command,
    input  logic [31:0] s_period,
    input  logic        s_handler_present,
    input  logic [7:0]  s_handler_id,
    input  logic [15:0] s_argument_tag,
    input  logic [7:0]  s_disable_mask,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [2:0]  m_slot,
    output logic [7:0]  m_expired_handler,
    output logic [15:0] m_expired_tag,
    output logic        m_last
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    logic [31:0] rld_mem [SLOTS];
    logic [31:0] rem_mem [SLOTS];
    logic [7:0]  hdl_mem [SLOTS];
    logic [15:0] tag_mem [SLOTS];

    logic [31:0] rld_q, rem_q;
    logic [7:0]  hdl_q;
    logic [15:0] tag_q;

    logic             cmd_reg, present_reg;
    logic [31:0]      period_reg;
    logic [7:0]       hid_reg, mask_reg;
    logic [15:0]      tag_reg;

    logic [SLOTS-1:0] active_reg, active_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [3:0]       cnt_reg, cnt_next;

    logic             pend_v_reg, pend_v_next;
    logic [2:0]       pend_slot_reg, pend_slot_next;
    logic [7:0]       pend_hdl_reg, pend_hdl_next;
    logic [15:0]      pend_tag_reg, pend_tag_next;

    logic             m_valid_reg, m_valid_next;
    logic [1:0]       kind_reg, kind_next;
    logic [2:0]       slot_reg, slot_next;
    logic [7:0]       hdl_out_reg, hdl_out_next;
    logic [15:0]      tag_out_reg, tag_out_next;
    logic             last_reg, last_next;

    logic [31:0] idx_ext;
    logic [31:0] dec;
    logic        cur_active, expire, off, report, out_free;
    logic        rem_we;
    logic [31:0] rem_wdata;

    assign idx_ext    = 32'(idx_reg);
    assign cur_active = active_reg[idx_reg];
    assign dec        = rem_q - 32'd1;
    assign expire     = cur_active && (dec == 32'd0);
    assign off        = (idx_ext < 32'd8) && mask_reg[idx_ext[2:0]];
    assign report     = expire && (cnt_reg < MAX_RESULTS);
    assign out_free   = !m_valid_reg || m_ready;

    assign sts.cmd_tick      = (cmd_reg == CMD_TICK);
    assign sts.add_bad       = (period_reg == 32'd0) || !present_reg;
    assign sts.cur_active    = cur_active;
    assign sts.idx_last      = (idx_reg == LAST_IDX);
    assign sts.out_free      = out_free;
    assign sts.upd_needs_out = report && pend_v_reg;

    // slot stores
    always_comb begin
        rem_we    = 1'b0;
        rem_wdata = dec;
        if (ctl.add_take) begin
            rem_we    = 1'b1;
            rem_wdata = period_reg;
        end else if (ctl.tick_upd && cur_active) begin
            rem_we = 1'b1;
            if (expire) begin
                rem_wdata = off ? 32'd0 : rld_q;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.add_take) begin
            rld_mem[idx_reg] <= period_reg;
            hdl_mem[idx_reg] <= hid_reg;
            tag_mem[idx_reg] <= tag_reg;
        end
        if (rem_we) begin
            rem_mem[idx_reg] <= rem_wdata;
        end
        if (ctl.tick_rd) begin
            rld_q <= rld_mem[idx_reg];
            rem_q <= rem_mem[idx_reg];
            hdl_q <= hdl_mem[idx_reg];
            tag_q <= tag_mem[idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.capture) begin
            cmd_reg     <= s_command;
            period_reg  <= s_period;
            present_reg <= s_handler_present;
            hid_reg     <= s_handler_id;
            tag_reg     <= s_argument_tag;
            mask_reg    <= s_disable_mask;
        end
        pend_slot_reg <= pend_slot_next;
        pend_hdl_reg  <= pend_hdl_next;
        pend_tag_reg  <= pend_tag_next;
        kind_reg      <= kind_next;
        slot_reg      <= slot_next;
        hdl_out_reg   <= hdl_out_next;
        tag_out_reg   <= tag_out_next;
        last_reg      <= last_next;
    end

    always_comb begin
        active_next    = active_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        pend_v_next    = pend_v_reg;
        pend_slot_next = pend_slot_reg;
        pend_hdl_next  = pend_hdl_reg;
        pend_tag_next  = pend_tag_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        kind_next      = kind_reg;
        slot_next      = slot_reg;
        hdl_out_next   = hdl_out_reg;
        tag_out_next   = tag_out_reg;
        last_next      = last_reg;

        if (ctl.capture) begin
            idx_next    = '0;
            cnt_next    = '0;
            pend_v_next = 1'b0;
        end
        if (ctl.idx_inc) begin
            idx_next = idx_reg + IDX_W'(1);
        end
        if (ctl.add_take) begin
            active_next[idx_reg] = 1'b1;
            m_valid_next = 1'b1;
            kind_next    = KIND_ADD_OK;
            slot_next    = 3'(idx_reg);
            hdl_out_next = '0;
            tag_out_next = '0;
            last_next    = 1'b1;
        end
        if (ctl.add_reject) begin
            m_valid_next = 1'b1;
            kind_next    = KIND_ADD_REJ;
            slot_next    = '0;
            hdl_out_next = '0;
            tag_out_next = '0;
            last_next    = 1'b1;
        end
        if (ctl.tick_upd) begin
            if (expire && off) begin
                active_next[idx_reg] = 1'b0;
            end
            if (report) begin
                if (pend_v_reg) begin
                    m_valid_next = 1'b1;
                    kind_next    = KIND_EXPIRY;
                    slot_next    = pend_slot_reg;
                    hdl_out_next = pend_hdl_reg;
                    tag_out_next = pend_tag_reg;
                    last_next    = 1'b0;
                end
                pend_v_next    = 1'b1;
                pend_slot_next = 3'(idx_reg);
                pend_hdl_next  = hdl_q;
                pend_tag_next  = tag_q;
                cnt_next       = cnt_reg + 4'd1;
            end
        end
        if (ctl.tick_fin) begin
            m_valid_next = 1'b1;
            last_next    = 1'b1;
            if (pend_v_reg) begin
                kind_next    = KIND_EXPIRY;
                slot_next    = pend_slot_reg;
                hdl_out_next = pend_hdl_reg;
                tag_out_next = pend_tag_reg;
            end else begin
                kind_next    = KIND_NO_EXP;
                slot_next    = '0;
                hdl_out_next = '0;
                tag_out_next = '0;
            end
            pend_v_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= '0;
            idx_reg     <= '0;
            cnt_reg     <= '0;
            pend_v_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            active_reg  <= active_next;
            idx_reg     <= idx_next;
            cnt_reg     <= cnt_next;
            pend_v_reg  <= pend_v_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_kind            = kind_reg;
    assign m_slot            = slot_reg;
    assign m_expired_handler = hdl_out_reg;
    assign m_expired_tag     = tag_out_reg;
    assign m_last            = last_reg;

endmodule
